/* rtl/tle_pkg.sv */
// Shared types and constants for the two-lane exclusion update block.
// Holds lattice geometry, rate constants, event and mode codes, payload structs.
// No dependencies.
package tle_pkg;

   localparam int SITES        = 1024;
   localparam int SITE_W       = $clog2(SITES);
   localparam int BANK_DEPTH   = (SITES + 1) / 2;
   localparam int BANK_W       = $clog2(BANK_DEPTH);
   localparam int RATE_W       = 17;
   localparam int COIN_W       = 16;
   localparam int SITE_FIELD_W = 11;
   localparam int CSR_ADDR_W   = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

   localparam logic [RATE_W-1:0] INJECT_RATE_A_RST = RATE_W'(26214);
   localparam logic [RATE_W-1:0] EXIT_RATE_A_RST   = RATE_W'(13107);
   localparam logic [RATE_W-1:0] INJECT_RATE_B_RST = RATE_W'(66);
   localparam logic [RATE_W-1:0] EXIT_RATE_B_RST   = RATE_W'(52429);
   localparam logic [RATE_W-1:0] COUPLING_RST      = RATE_W'(0);

   localparam logic [CSR_ADDR_W-1:0] CSR_INJECT_RATE_A = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXIT_RATE_A   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INJECT_RATE_B = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXIT_RATE_B   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COUPLING      = 3'd4;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_LOAD   = 2'd2;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_INJECT  = 3'd1;
   localparam logic [2:0] EV_REMOVE  = 3'd2;
   localparam logic [2:0] EV_HOP     = 3'd3;
   localparam logic [2:0] EV_REJECT  = 3'd4;
   localparam logic [2:0] EV_BLOCKED = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ,
      OP_LOAD,
      OP_INJECT,
      OP_EXIT,
      OP_HOP
   } op_kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_FETCH,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic                    lane;
      logic [SITE_FIELD_W-1:0] site;
      logic [COIN_W-1:0]       coin;
      logic                    load_a;
      logic                    load_b;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic       occupied_a;
      logic       occupied_b;
   } rsp_type;

   typedef struct packed {
      logic [RATE_W-1:0] inject_rate_a;
      logic [RATE_W-1:0] exit_rate_a;
      logic [RATE_W-1:0] inject_rate_b;
      logic [RATE_W-1:0] exit_rate_b;
      logic [RATE_W-1:0] coupling;
   } cfg_type;

   typedef struct packed {
      op_kind_type       kind;
      logic              lane;
      logic              cur_odd;
      logic [BANK_W-1:0] even_addr;
      logic [BANK_W-1:0] odd_addr;
      logic [COIN_W-1:0] coin;
      logic              load_a;
      logic              load_b;
      logic [RATE_W-1:0] rate;
   } job_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

endpackage

/* rtl/tle_front.sv */
// Front end: classifies incoming transactions into jobs and queues them.
// Depends on tle_pkg.
module tle_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  tle_pkg::req_type      req_data,
   input  tle_pkg::cfg_type      cfg,
   input  tle_pkg::back_ctl_type bk_ctl,
   output logic                  q_valid,
   output tle_pkg::job_type      q_data
);

   tle_pkg::job_type                 job_in;
   tle_pkg::job_type                 q_mem_ff [tle_pkg::QUEUE_DEPTH];
   logic [tle_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [tle_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [tle_pkg::QCNT_W-1:0]       count_ff;
   logic [tle_pkg::QCNT_W-1:0]       count_in;
   logic                             push;
   logic                             in_range;
   logic                             is_slot;
   logic [tle_pkg::SITE_W-1:0]       idx;
   logic [tle_pkg::SITE_W:0]         idx_next;

   assign in_range = req_data.site <= tle_pkg::SITE_FIELD_W'(tle_pkg::SITES);
   assign is_slot  = req_data.site == tle_pkg::SITE_FIELD_W'(tle_pkg::SITES);
   assign idx      = is_slot ? '0 : req_data.site[tle_pkg::SITE_W-1:0];
   assign idx_next = {1'b0, idx} + 1'b1;

   always_comb begin
      job_in.lane      = req_data.lane;
      job_in.cur_odd   = idx[0];
      job_in.odd_addr  = tle_pkg::BANK_W'(idx >> 1);
      job_in.even_addr = idx[0] ? tle_pkg::BANK_W'(idx_next >> 1)
                                : tle_pkg::BANK_W'(idx >> 1);
      job_in.coin      = req_data.coin;
      job_in.load_a    = req_data.load_a;
      job_in.load_b    = req_data.load_b;
      job_in.rate      = '0;
      job_in.kind      = tle_pkg::OP_READ;
      if (!in_range) begin
         job_in.kind = tle_pkg::OP_NONE;
      end else if (req_data.mode == tle_pkg::MODE_UPDATE) begin
         if (is_slot) begin
            job_in.kind = tle_pkg::OP_INJECT;
            job_in.rate = req_data.lane ? cfg.inject_rate_b : cfg.inject_rate_a;
         end else if (idx == tle_pkg::SITE_W'(tle_pkg::SITES - 1)) begin
            job_in.kind = tle_pkg::OP_EXIT;
            job_in.rate = req_data.lane ? cfg.exit_rate_b : cfg.exit_rate_a;
         end else begin
            job_in.kind = tle_pkg::OP_HOP;
         end
      end else if (req_data.mode == tle_pkg::MODE_LOAD && !is_slot) begin
         job_in.kind = tle_pkg::OP_LOAD;
      end
   end

   assign req_full = (count_ff == tle_pkg::QCNT_W'(tle_pkg::QUEUE_DEPTH)) || bk_ctl.clearing;
   assign push     = req_push && !req_full;
   assign q_valid  = count_ff != '0;
   assign q_data   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !bk_ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && bk_ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (bk_ctl.pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

/* rtl/tle_back.sv */
// Back end: lattice banks, read-decide-write sequencer and result register.
// Depends on tle_pkg.
module tle_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  tle_pkg::job_type         q_data,
   input  logic [tle_pkg::RATE_W-1:0] coupling,
   output tle_pkg::back_ctl_type    bk_ctl,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output tle_pkg::rsp_type         rsp_data
);

   tle_pkg::back_state_type     state_ff;
   tle_pkg::back_state_type     state_in;
   logic [tle_pkg::BANK_W-1:0]  clr_ff;
   logic                        clr_done;
   tle_pkg::job_type            job_ff;
   logic [1:0]                  bank_even_ff [tle_pkg::BANK_DEPTH];
   logic [1:0]                  bank_odd_ff  [tle_pkg::BANK_DEPTH];
   logic [1:0]                  rd_even_ff;
   logic [1:0]                  rd_odd_ff;
   logic                        out_valid_ff;
   tle_pkg::rsp_type            out_ff;
   tle_pkg::rsp_type            out_in;
   logic                        fetch;
   logic                        commit;

   logic [1:0]                  cur_pair;
   logic [1:0]                  nxt_pair;
   logic [1:0]                  new_cur;
   logic [1:0]                  new_nxt;
   logic                        wr_cur;
   logic                        wr_nxt;
   logic                        me_cur;
   logic                        me_nxt;
   logic [1:0]                  k;
   logic [tle_pkg::RATE_W:0]    half_sum;
   logic [tle_pkg::RATE_W-1:0]  hop_rate;
   logic [tle_pkg::RATE_W-1:0]  rate_sel;
   logic                        coin_ok;
   logic [2:0]                  ev;

   logic                        even_we;
   logic                        odd_we;
   logic [tle_pkg::BANK_W-1:0]  even_wa;
   logic [tle_pkg::BANK_W-1:0]  odd_wa;
   logic [1:0]                  even_wd;
   logic [1:0]                  odd_wd;

   assign clr_done = clr_ff == tle_pkg::BANK_W'(tle_pkg::BANK_DEPTH - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tle_pkg::BK_CLEAR: begin
            if (clr_done) state_in = tle_pkg::BK_FETCH;
         end
         tle_pkg::BK_FETCH: begin
            if (q_valid) state_in = tle_pkg::BK_EXEC;
         end
         tle_pkg::BK_EXEC: begin
            if (!out_valid_ff || rsp_pop) state_in = tle_pkg::BK_FETCH;
         end
         default: state_in = tle_pkg::BK_CLEAR;
      endcase
   end

   always_comb begin
      fetch           = (state_ff == tle_pkg::BK_FETCH) && q_valid;
      commit          = (state_ff == tle_pkg::BK_EXEC) && (!out_valid_ff || rsp_pop);
      bk_ctl.pop      = fetch;
      bk_ctl.clearing = state_ff == tle_pkg::BK_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tle_pkg::BK_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (bk_ctl.clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      cur_pair = job_ff.cur_odd ? rd_odd_ff : rd_even_ff;
      nxt_pair = job_ff.cur_odd ? rd_even_ff : rd_odd_ff;
      me_cur   = cur_pair[job_ff.lane];
      me_nxt   = nxt_pair[job_ff.lane];
      k        = {1'b0, cur_pair[!job_ff.lane]} + {1'b0, nxt_pair[!job_ff.lane]};
      half_sum = ({1'b0, tle_pkg::RATE_ONE} + {1'b0, coupling}) >> 1;
      unique case (k)
         2'd0:    hop_rate = tle_pkg::RATE_ONE;
         2'd1:    hop_rate = half_sum[tle_pkg::RATE_W-1:0];
         default: hop_rate = coupling;
      endcase
      rate_sel = (job_ff.kind == tle_pkg::OP_HOP) ? hop_rate : job_ff.rate;
      coin_ok  = {1'b0, job_ff.coin} < rate_sel;
   end

   always_comb begin
      new_cur = cur_pair;
      new_nxt = nxt_pair;
      wr_cur  = 1'b0;
      wr_nxt  = 1'b0;
      ev      = tle_pkg::EV_NONE;
      unique case (job_ff.kind)
         tle_pkg::OP_INJECT: begin
            if (me_cur) begin
               ev = tle_pkg::EV_BLOCKED;
            end else if (!coin_ok) begin
               ev = tle_pkg::EV_REJECT;
            end else begin
               new_cur[job_ff.lane] = 1'b1;
               wr_cur = 1'b1;
               ev     = tle_pkg::EV_INJECT;
            end
         end
         tle_pkg::OP_EXIT: begin
            if (!me_cur) begin
               ev = tle_pkg::EV_NONE;
            end else if (!coin_ok) begin
               ev = tle_pkg::EV_REJECT;
            end else begin
               new_cur[job_ff.lane] = 1'b0;
               wr_cur = 1'b1;
               ev     = tle_pkg::EV_REMOVE;
            end
         end
         tle_pkg::OP_HOP: begin
            if (!me_cur) begin
               ev = tle_pkg::EV_NONE;
            end else if (me_nxt) begin
               ev = tle_pkg::EV_BLOCKED;
            end else if (!coin_ok) begin
               ev = tle_pkg::EV_REJECT;
            end else begin
               new_cur[job_ff.lane] = 1'b0;
               new_nxt[job_ff.lane] = 1'b1;
               wr_cur = 1'b1;
               wr_nxt = 1'b1;
               ev     = tle_pkg::EV_HOP;
            end
         end
         tle_pkg::OP_LOAD: begin
            new_cur = {job_ff.load_b, job_ff.load_a};
            wr_cur  = 1'b1;
         end
         tle_pkg::OP_READ, tle_pkg::OP_NONE: begin
            ev = tle_pkg::EV_NONE;
         end
         default: ev = tle_pkg::EV_NONE;
      endcase
      out_in.event_res  = ev;
      out_in.occupied_a = (job_ff.kind == tle_pkg::OP_NONE) ? 1'b0 : new_cur[0];
      out_in.occupied_b = (job_ff.kind == tle_pkg::OP_NONE) ? 1'b0 : new_cur[1];
   end

   always_comb begin
      if (bk_ctl.clearing) begin
         even_we = 1'b1;
         odd_we  = 1'b1;
         even_wa = clr_ff;
         odd_wa  = clr_ff;
         even_wd = 2'b00;
         odd_wd  = 2'b00;
      end else begin
         even_we = commit && (job_ff.cur_odd ? wr_nxt : wr_cur);
         odd_we  = commit && (job_ff.cur_odd ? wr_cur : wr_nxt);
         even_wa = job_ff.even_addr;
         odd_wa  = job_ff.odd_addr;
         even_wd = job_ff.cur_odd ? new_nxt : new_cur;
         odd_wd  = job_ff.cur_odd ? new_cur : new_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (even_we) begin
         bank_even_ff[even_wa] <= even_wd;
      end
      if (odd_we) begin
         bank_odd_ff[odd_wa] <= odd_wd;
      end
      if (fetch) begin
         rd_even_ff <= bank_even_ff[q_data.even_addr];
         rd_odd_ff  <= bank_odd_ff[q_data.odd_addr];
         job_ff     <= q_data;
      end
      if (commit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* rtl/two_lane_exclusion_update.sv */
// Top level of the two-lane exclusion update block: rate registers, front, back.
// Depends on tle_pkg, tle_front and tle_back.
//
// Two occupancy lattices of SITES sites each are kept in two banks, even and
// odd sites, each bank holding both lanes, so a site and its right neighbor
// in both lanes are read in the same cycle. In the back end every transaction
// passes a bank read and then decision and write-back, which waits while an
// earlier result is not yet popped; the next transaction is fetched only once
// the last is written back. A two-entry queue sits between front and back,
// and the result register lets the next transaction proceed up to the
// write-back while a result waits. After reset all (SITES+1)/2 (512) addresses
// of both banks are swept to empty, with req_full held high; rate registers
// may be written during that time.
module two_lane_exclusion_update (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  tle_pkg::req_type               req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output tle_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [tle_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [tle_pkg::RATE_W-1:0]     csr_wdata
);

   tle_pkg::cfg_type      cfg_ff;
   tle_pkg::back_ctl_type bk_ctl;
   logic                  q_valid;
   tle_pkg::job_type      q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inject_rate_a <= tle_pkg::INJECT_RATE_A_RST;
         cfg_ff.exit_rate_a   <= tle_pkg::EXIT_RATE_A_RST;
         cfg_ff.inject_rate_b <= tle_pkg::INJECT_RATE_B_RST;
         cfg_ff.exit_rate_b   <= tle_pkg::EXIT_RATE_B_RST;
         cfg_ff.coupling      <= tle_pkg::COUPLING_RST;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            tle_pkg::CSR_INJECT_RATE_A: cfg_ff.inject_rate_a <= csr_wdata;
            tle_pkg::CSR_EXIT_RATE_A:   cfg_ff.exit_rate_a   <= csr_wdata;
            tle_pkg::CSR_INJECT_RATE_B: cfg_ff.inject_rate_b <= csr_wdata;
            tle_pkg::CSR_EXIT_RATE_B:   cfg_ff.exit_rate_b   <= csr_wdata;
            tle_pkg::CSR_COUPLING:      cfg_ff.coupling      <= csr_wdata;
            default: ;
         endcase
      end
   end

   tle_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .bk_ctl   (bk_ctl),
      .q_valid  (q_valid),
      .q_data   (q_data)
   );

   tle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .coupling  (cfg_ff.coupling),
      .bk_ctl    (bk_ctl),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      bk_ctl.clearing |-> req_full)
      else $error("input taken during bank clear");

   a_occupied_after_inject_or_block: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.event_res == tle_pkg::EV_INJECT ||
                      rsp_data.event_res == tle_pkg::EV_BLOCKED))
      |-> (rsp_data.occupied_a || rsp_data.occupied_b))
      else $error("inject or blocked result reports an empty site");

   a_pop_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      bk_ctl.pop |-> q_valid && !bk_ctl.clearing)
      else $error("back end popped an empty queue");

endmodule

/* verif/tb_two_lane_exclusion_update.sv */
// Self-checking testbench for two_lane_exclusion_update: directed and random lattice traffic
// under several rate settings, with results checked against an in-bench lattice predictor.
// Depends on tle_pkg and the two_lane_exclusion_update RTL.
module tb_two_lane_exclusion_update;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]                     MODE_SPARE  = 2'd3;
   localparam logic [tle_pkg::CSR_ADDR_W-1:0] CSR_UNUSED  = 3'd7;
   localparam logic [tle_pkg::RATE_W-1:0]     RATE_ALL    = 17'h1FFFF;
   localparam int                             CYCLE_LIMIT = 200000;
   localparam int                             PHASE_ITEMS = 300;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   tle_pkg::req_type               req_data = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   tle_pkg::rsp_type               rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [tle_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [tle_pkg::RATE_W-1:0]     csr_wdata = '0;

   bit                         lattice [2][tle_pkg::SITES];
   logic [tle_pkg::RATE_W-1:0] inj_rate [2];
   logic [tle_pkg::RATE_W-1:0] ext_rate [2];
   logic [tle_pkg::RATE_W-1:0] coupling_rate;

   tle_pkg::req_type req_backlog [$];
   tle_pkg::rsp_type want_rsp [$];
   int      outstanding = 0;
   int      errors = 0;
   int      cycles = 0;
   int      req_count = 0;
   int      ev_tally [8];
   bit      req_taken = 1'b0;
   bit      steady = 1'b0;

   two_lane_exclusion_update i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic tle_pkg::rsp_type step_lattice(tle_pkg::req_type r);
      tle_pkg::rsp_type o;
      logic [2:0]       ev;
      int               me;
      int               ot;
      int               st;
      int               k;
      int               hop_rate;
      o = '0;
      ev = tle_pkg::EV_NONE;
      st = int'(r.site);
      if (st > tle_pkg::SITES) return o;
      if (r.mode == tle_pkg::MODE_UPDATE) begin
         me = r.lane ? 1 : 0;
         ot = 1 - me;
         if (st == tle_pkg::SITES) begin
            if (lattice[me][0]) ev = tle_pkg::EV_BLOCKED;
            else if ({1'b0, r.coin} < inj_rate[me]) begin
               lattice[me][0] = 1'b1;
               ev = tle_pkg::EV_INJECT;
            end else ev = tle_pkg::EV_REJECT;
         end else if (st == tle_pkg::SITES - 1) begin
            if (!lattice[me][tle_pkg::SITES-1]) ev = tle_pkg::EV_NONE;
            else if ({1'b0, r.coin} < ext_rate[me]) begin
               lattice[me][tle_pkg::SITES-1] = 1'b0;
               ev = tle_pkg::EV_REMOVE;
            end else ev = tle_pkg::EV_REJECT;
         end else if (!lattice[me][st]) begin
            ev = tle_pkg::EV_NONE;
         end else if (lattice[me][st+1]) begin
            ev = tle_pkg::EV_BLOCKED;
         end else begin
            k = int'(lattice[ot][st]) + int'(lattice[ot][st+1]);
            if (k == 0) hop_rate = 65536;
            else if (k == 1) hop_rate = (65536 + int'(coupling_rate)) >> 1;
            else hop_rate = int'(coupling_rate);
            if (int'(r.coin) < hop_rate) begin
               lattice[me][st] = 1'b0;
               lattice[me][st+1] = 1'b1;
               ev = tle_pkg::EV_HOP;
            end else ev = tle_pkg::EV_REJECT;
         end
      end else if (r.mode == tle_pkg::MODE_LOAD && st < tle_pkg::SITES) begin
         lattice[0][st] = r.load_a;
         lattice[1][st] = r.load_b;
      end
      if (st == tle_pkg::SITES) st = 0;
      o.event_res  = ev;
      o.occupied_a = lattice[0][st];
      o.occupied_b = lattice[1][st];
      return o;
   endfunction

   function automatic tle_pkg::req_type mk_req(logic [1:0] m, logic ln, int st, int cn,
                                               logic la, logic lb);
      tle_pkg::req_type r;
      r.mode   = m;
      r.lane   = ln;
      r.site   = tle_pkg::SITE_FIELD_W'(st);
      r.coin   = tle_pkg::COIN_W'(cn);
      r.load_a = la;
      r.load_b = lb;
      return r;
   endfunction

   function automatic tle_pkg::req_type random_req();
      tle_pkg::req_type r;
      int               pick;
      int               where;
      int               c;
      pick  = $urandom_range(99);
      where = $urandom_range(99);
      c     = $urandom_range(9);
      r.lane   = 1'($urandom_range(1));
      r.load_a = 1'($urandom_range(1));
      r.load_b = 1'($urandom_range(1));
      if (c == 0) r.coin = '0;
      else if (c == 1) r.coin = 16'hFFFF;
      else r.coin = tle_pkg::COIN_W'($urandom_range(16'hFFFF));
      if (where < 18) r.site = tle_pkg::SITE_FIELD_W'(tle_pkg::SITES);
      else if (where < 32) r.site = tle_pkg::SITE_FIELD_W'(tle_pkg::SITES - 1);
      else if (where < 62) r.site = tle_pkg::SITE_FIELD_W'($urandom_range(14));
      else if (where < 86) begin
         r.site = tle_pkg::SITE_FIELD_W'($urandom_range(tle_pkg::SITES - 2,
                                                        tle_pkg::SITES - 12));
      end else r.site = tle_pkg::SITE_FIELD_W'($urandom_range(tle_pkg::SITES - 1));
      if (pick < 62) r.mode = tle_pkg::MODE_UPDATE;
      else if (pick < 75) r.mode = tle_pkg::MODE_LOAD;
      else if (pick < 85) r.mode = tle_pkg::MODE_READ;
      else begin
         r.mode = 2'($urandom_range(3));
         if ($urandom_range(1)) begin
            r.site = tle_pkg::SITE_FIELD_W'($urandom_range(2047, tle_pkg::SITES + 1));
         end else r.site = tle_pkg::SITE_FIELD_W'($urandom_range(2047));
      end
      return r;
   endfunction

   task automatic queue_req(tle_pkg::req_type r);
      req_backlog.push_back(r);
      outstanding++;
      req_count++;
   endtask

   task automatic write_rate(logic [tle_pkg::CSR_ADDR_W-1:0] idx,
                             logic [tle_pkg::RATE_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         tle_pkg::CSR_INJECT_RATE_A: inj_rate[0] = val;
         tle_pkg::CSR_EXIT_RATE_A:   ext_rate[0] = val;
         tle_pkg::CSR_INJECT_RATE_B: inj_rate[1] = val;
         tle_pkg::CSR_EXIT_RATE_B:   ext_rate[1] = val;
         tle_pkg::CSR_COUPLING:      coupling_rate = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_rates(logic [tle_pkg::RATE_W-1:0] ia, logic [tle_pkg::RATE_W-1:0] ea,
                            logic [tle_pkg::RATE_W-1:0] ib, logic [tle_pkg::RATE_W-1:0] eb,
                            logic [tle_pkg::RATE_W-1:0] cp);
      write_rate(tle_pkg::CSR_INJECT_RATE_A, ia);
      write_rate(tle_pkg::CSR_EXIT_RATE_A, ea);
      write_rate(tle_pkg::CSR_INJECT_RATE_B, ib);
      write_rate(tle_pkg::CSR_EXIT_RATE_B, eb);
      write_rate(tle_pkg::CSR_COUPLING, cp);
   endtask

   task automatic fill_random(int n);
      for (int i = 0; i < n; i++) queue_req(random_req());
   endtask

   task automatic drain();
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   always @(negedge clock) begin : drive_req
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
            req_data <= req_backlog.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : drive_pop
      rsp_pop <= !reset && (steady || $urandom_range(99) >= 22);
   end

   always @(posedge clock) begin : watch
      tle_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (want_rsp.size() == 0) begin
            $error("unexpected result transaction: event_res %0d occupied_a %0d occupied_b %0d",
                   rsp_data.event_res, rsp_data.occupied_a, rsp_data.occupied_b);
            errors++;
         end else begin
            want = want_rsp.pop_front();
            outstanding--;
            ev_tally[want.event_res]++;
            if (rsp_data.event_res !== want.event_res) begin
               $error("event_res expected %0d actual %0d", want.event_res, rsp_data.event_res);
               errors++;
            end
            if (rsp_data.occupied_a !== want.occupied_a) begin
               $error("occupied_a expected %0d actual %0d", want.occupied_a,
                      rsp_data.occupied_a);
               errors++;
            end
            if (rsp_data.occupied_b !== want.occupied_b) begin
               $error("occupied_b expected %0d actual %0d", want.occupied_b,
                      rsp_data.occupied_b);
               errors++;
            end
         end
      end
      if (!reset && req_push && !req_full) want_rsp.push_back(step_lattice(req_data));
      req_taken <= !reset && req_push && !req_full;
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_two_lane_exclusion_update: done, errors");
         $finish;
      end
   end

   initial begin : sequencer
      inj_rate[0]   = tle_pkg::INJECT_RATE_A_RST;
      ext_rate[0]   = tle_pkg::EXIT_RATE_A_RST;
      inj_rate[1]   = tle_pkg::INJECT_RATE_B_RST;
      ext_rate[1]   = tle_pkg::EXIT_RATE_B_RST;
      coupling_rate = tle_pkg::COUPLING_RST;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset rates, empty lattice
      queue_req(mk_req(tle_pkg::MODE_READ,   0, 0,                  0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, tle_pkg::SITES - 1, 0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, 5,                  0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, tle_pkg::SITES,     0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, tle_pkg::SITES,     0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 1, tle_pkg::SITES,     65535, 0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 1, tle_pkg::SITES,     65,    0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, 0,                  32768, 0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, 0,                  32767, 0, 0));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, tle_pkg::SITES - 1, 0,     1, 1));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, tle_pkg::SITES,     0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, tle_pkg::SITES - 1, 13107, 0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, tle_pkg::SITES - 1, 13106, 0, 0));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, 10,                 0,     1, 0));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, 11,                 0,     1, 1));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, 10,                 0,     0, 0));
      queue_req(mk_req(MODE_SPARE,           0, 11,                 0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 1, 2047,               0,     1, 1));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   1, 2047,               65535, 1, 1));
      queue_req(mk_req(tle_pkg::MODE_READ,   0, tle_pkg::SITES,     0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, 20,                 0,     1, 1));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, 21,                 0,     0, 1));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, 20,                 0,     0, 0));
      queue_req(mk_req(tle_pkg::MODE_LOAD,   0, tle_pkg::SITES - 2, 0,     1, 0));
      queue_req(mk_req(tle_pkg::MODE_UPDATE, 0, tle_pkg::SITES - 2, 0,     0, 0));
      fill_random(PHASE_ITEMS);
      drain();

      set_rates(tle_pkg::RATE_ONE, tle_pkg::RATE_ONE, tle_pkg::RATE_ONE, tle_pkg::RATE_ONE,
                tle_pkg::RATE_ONE);
      fill_random(PHASE_ITEMS);
      drain();

      set_rates('0, '0, '0, '0, '0);
      fill_random(PHASE_ITEMS);
      drain();

      set_rates(RATE_ALL, RATE_ALL, RATE_ALL, RATE_ALL, RATE_ALL);
      fill_random(PHASE_ITEMS);
      drain();

      set_rates(tle_pkg::RATE_W'($urandom_range(65536)), tle_pkg::RATE_W'($urandom_range(65536)),
                tle_pkg::RATE_W'($urandom_range(65536)), tle_pkg::RATE_W'($urandom_range(65536)),
                tle_pkg::RATE_W'($urandom_range(65536)));
      write_rate(CSR_UNUSED, tle_pkg::RATE_W'($urandom_range(RATE_ALL)));
      steady = 1'b1;
      fill_random(PHASE_ITEMS);
      drain();
      steady = 1'b0;

      set_rates(17'd40000, 17'd30000, 17'd50000, 17'd20000, 17'd20000);
      fill_random(PHASE_ITEMS);
      drain();

      $display("covered %0d transactions over 6 rate settings in %0d cycles",
               req_count, cycles);
      $display("events: none %0d inject %0d remove %0d hop %0d reject %0d blocked %0d",
               ev_tally[tle_pkg::EV_NONE], ev_tally[tle_pkg::EV_INJECT],
               ev_tally[tle_pkg::EV_REMOVE], ev_tally[tle_pkg::EV_HOP],
               ev_tally[tle_pkg::EV_REJECT], ev_tally[tle_pkg::EV_BLOCKED]);
      if (errors == 0) begin
         $display("tb_two_lane_exclusion_update: done, clean");
      end else begin
         $display("tb_two_lane_exclusion_update: done, errors");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/tle_pkg.sv
rtl/tle_front.sv
rtl/tle_back.sv
rtl/two_lane_exclusion_update.sv
verif/tb_two_lane_exclusion_update.sv
